FILE: src/mam_pkg.sv
// shared constants and codes for the matrix add/multiply engine
`default_nettype none

package mam_pkg;

    localparam int MAX_DIM     = 16;
    localparam int ELEM_W      = 32;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    // input word layout
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [DIM_W-1:0]    dim_t;
    typedef logic [ELEM_W-1:0]   elem_t;

    localparam cmd_t CMD_WR_A = 2'd0;
    localparam cmd_t CMD_WR_B = 2'd1;
    localparam cmd_t CMD_SUM  = 2'd2;
    localparam cmd_t CMD_PROD = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_DIM   = 2'd1;
    localparam status_t ST_INDEX = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

    // dimension register holds a usable size
    function automatic logic dim_ok(input dim_t d);
        dim_ok = (d != '0) && (d <= dim_t'(MAX_DIM));
    endfunction

endpackage

`default_nettype wire

FILE: src/mam_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module mam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/matrix_add_multiply_engine_core.sv
// top level of the matrix add/multiply engine
//
// usage: write the four dimension registers (rows_a, cols_a, rows_b, cols_b)
// through the cfg port while idle, then send command words on the s_ stream.
// write-A / write-B words store one element and give no result word; the block
// stays ready after them, so writes can follow back to back. sum and product reads
// give exactly one result word on the m_ stream holding the value and status.
// a sum read adds the two elements at (row, col); a product read is done by the single
// multiply-accumulate unit that walks the inner index one element pair per cycle
// out of the two stores. a read that fails the dimension or index check skips
// that unit and answers with a zero value. only one read is in flight; s_tready
// is low while it runs and comes back with m_tvalid, so a new read is taken only
// once the last one has put its result word in the output register.
// the result sits in an output register, so a stalled receiver does not keep
// a new word from being taken; the next result waits until that one is taken.
// reset (aresetn low, synchronous) sets all dimensions to 1 and empties the
// output register; the element stores are not cleared and must be written
// before they are read.
`default_nettype none

module matrix_add_multiply_engine_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [mam_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [mam_pkg::DIM_W-1:0]         cfg_wdata,
    // command stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // command[1:0], row_index[5:2], col_index[9:6], write_value[41:10], zero fill
    input  wire logic [mam_pkg::IN_DATA_W-1:0]     s_tdata,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // result_value[31:0], status[33:32], zero fill
    output logic      [mam_pkg::OUT_DATA_W-1:0]    m_tdata
);

    import mam_pkg::*;

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] S_IDLE  = 2'd0;
    localparam logic [ST_W-1:0] S_MAC   = 2'd1;
    localparam logic [ST_W-1:0] S_DRAIN = 2'd2;
    localparam logic [ST_W-1:0] S_OUT   = 2'd3;

    // input word fields
    cmd_t  in_cmd;
    idx_t  in_row;
    idx_t  in_col;
    elem_t in_value;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_row   = s_tdata[CMD_W+IDX_W-1:CMD_W];
    assign in_col   = s_tdata[CMD_W+2*IDX_W-1:CMD_W+IDX_W];
    assign in_value = s_tdata[CMD_W+2*IDX_W+ELEM_W-1:CMD_W+2*IDX_W];

    // dimension registers
    dim_t rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg <= dim_t'(1);
            cols_a_reg <= dim_t'(1);
            rows_b_reg <= dim_t'(1);
            cols_b_reg <= dim_t'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ROWS_A: rows_a_reg <= cfg_wdata;
                REG_COLS_A: cols_a_reg <= cfg_wdata;
                REG_ROWS_B: rows_b_reg <= cfg_wdata;
                REG_COLS_B: cols_b_reg <= cfg_wdata;
                default:    rows_a_reg <= rows_a_reg;
            endcase
        end
    end

    // sequencer and datapath registers
    logic [ST_W-1:0] state_reg, state_next;
    logic            sum_reg, sum_next;
    idx_t            row_reg, row_next;
    idx_t            col_reg, col_next;
    idx_t            k_reg, k_next;
    elem_t           acc_reg, acc_next;
    elem_t           res_reg, res_next;
    status_t         stat_reg, stat_next;

    // pipeline: ram read -> term (multiply or add) -> accumulate
    logic            rd_vld_reg, rd_last_reg;
    logic            term_vld_reg, term_last_reg;
    elem_t           term_reg;

    // output register
    logic            m_vld_reg, m_vld_next;
    elem_t           m_val_reg, m_val_next;
    status_t         m_stat_reg, m_stat_next;

    logic            s_accept;
    logic            issue;
    logic            issue_last;
    logic            sum_dim_err, sum_idx_err;
    logic            prod_dim_err, prod_idx_err;
    status_t         check_stat;
    logic            is_read;

    // store ports
    logic            we_a, we_b;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr_a, raddr_b;
    elem_t           rd_a, rd_b;
    elem_t           prod_full;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign is_read  = (in_cmd == CMD_SUM) || (in_cmd == CMD_PROD);

    // element writes go straight into the stores
    assign we_a  = s_accept && (in_cmd == CMD_WR_A);
    assign we_b  = s_accept && (in_cmd == CMD_WR_B);
    assign waddr = {in_row, in_col};

    // sum uses the element at (row, col) of both; product walks k
    assign issue      = (state_reg == S_MAC);
    assign raddr_a    = sum_reg ? {row_reg, col_reg} : {row_reg, k_reg};
    assign raddr_b    = sum_reg ? {row_reg, col_reg} : {k_reg, col_reg};
    assign issue_last = sum_reg || ({1'b0, k_reg} == (cols_a_reg - dim_t'(1)));

    mam_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_store_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (in_value),
        .raddr (raddr_a),
        .rdata (rd_a)
    );

    mam_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_store_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (in_value),
        .raddr (raddr_b),
        .rdata (rd_b)
    );

    // dimension check first, index check second
    assign sum_dim_err  = !dim_ok(rows_a_reg) || !dim_ok(cols_a_reg) ||
                          (rows_a_reg != rows_b_reg) || (cols_a_reg != cols_b_reg);
    assign sum_idx_err  = ({1'b0, in_row} >= rows_a_reg) || ({1'b0, in_col} >= cols_a_reg);
    assign prod_dim_err = !dim_ok(rows_a_reg) || !dim_ok(cols_a_reg) ||
                          !dim_ok(cols_b_reg) || (cols_a_reg != rows_b_reg);
    assign prod_idx_err = ({1'b0, in_row} >= rows_a_reg) || ({1'b0, in_col} >= cols_b_reg);

    always_comb begin
        check_stat = ST_OK;
        if (in_cmd == CMD_SUM) begin
            if (sum_dim_err) begin
                check_stat = ST_DIM;
            end else if (sum_idx_err) begin
                check_stat = ST_INDEX;
            end
        end else begin
            if (prod_dim_err) begin
                check_stat = ST_DIM;
            end else if (prod_idx_err) begin
                check_stat = ST_INDEX;
            end
        end
    end

    // shared arithmetic stage: one multiply or one add per cycle, low bits kept
    assign prod_full = rd_a * rd_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            term_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= issue;
            term_vld_reg <= rd_vld_reg;
        end
        rd_last_reg   <= issue_last;
        term_last_reg <= rd_last_reg;
        term_reg      <= sum_reg ? (rd_a + rd_b) : prod_full;
    end

    always_comb begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        res_next    = res_reg;
        stat_next   = stat_reg;
        m_vld_next  = m_vld_reg;
        m_val_next  = m_val_reg;
        m_stat_next = m_stat_reg;

        if (m_vld_reg && m_tready) begin
            m_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept && is_read) begin
                    sum_next  = (in_cmd == CMD_SUM);
                    row_next  = in_row;
                    col_next  = in_col;
                    k_next    = '0;
                    acc_next  = '0;
                    res_next  = '0;
                    stat_next = check_stat;
                    if (check_stat == ST_OK) begin
                        state_next = S_MAC;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_MAC: begin
                // issue one element pair per cycle
                if (issue_last) begin
                    state_next = S_DRAIN;
                end else begin
                    k_next = k_reg + idx_t'(1);
                end
            end
            S_DRAIN: begin
                if (term_vld_reg) begin
                    acc_next = acc_reg + term_reg;
                    if (term_last_reg) begin
                        res_next   = acc_reg + term_reg;
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!m_vld_reg || m_tready) begin
                    m_vld_next  = 1'b1;
                    m_val_next  = res_reg;
                    m_stat_next = stat_reg;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // terms also land while still issuing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_vld_reg <= m_vld_next;
        end
        sum_reg    <= sum_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        k_reg      <= k_next;
        res_reg    <= res_next;
        stat_reg   <= stat_next;
        m_val_reg  <= m_val_next;
        m_stat_reg <= m_stat_next;
        if (state_reg == S_MAC && term_vld_reg) begin
            acc_reg <= acc_reg + term_reg;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {{(OUT_DATA_W - ELEM_W - STATUS_W){1'b0}}, m_stat_reg, m_val_reg};

endmodule

`default_nettype wire

FILE: bench/matrix_add_multiply_engine_core_tb.sv
// self-checking stream testbench for the matrix add/multiply engine
module matrix_add_multiply_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mam_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000; // cycles without any accepted word
    localparam int HOLD_CYCLES    = 300;  // long receiver stall
    localparam int SETTLE_CYCLES  = 40;   // longer than a full-size product read
    localparam int NUM_PHASES     = 13;
    localparam int FIXED_PHASES   = 9;

    typedef logic [CFG_IDX_W-1:0] reg_idx_t;

    // one expected result word
    typedef struct packed {
        elem_t   value;
        status_t status;
    } outcome_t;

    // one row of the directed sequence: a command word or a register write
    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;
    typedef struct packed {
        row_kind_t kind;
        reg_idx_t  reg_idx;
        cmd_t      cmd;
        idx_t      row;
        idx_t      col;
        elem_t     value;
        logic      typed;
        elem_t     exp_value;
        status_t   exp_status;
    } drill_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_addr;
    logic [DIM_W-1:0]        cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    // command[1:0], row_index[5:2], col_index[9:6], write_value[41:10], zero fill
    logic [IN_DATA_W-1:0]    s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    // result_value[31:0], status[33:32], zero fill
    logic [OUT_DATA_W-1:0]   m_tdata;

    // shadow of the block: both element stores, which entries hold data, dimensions
    elem_t     shadow_a [STORE_DEPTH];
    elem_t     shadow_b [STORE_DEPTH];
    bit        loaded_a [STORE_DEPTH];
    bit        loaded_b [STORE_DEPTH];
    dim_t      dims [4] = '{dim_t'(1), dim_t'(1), dim_t'(1), dim_t'(1)};

    outcome_t  pending_results [$];
    int        errors = 0;
    int        sent_words = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        hold_req = 1'b0;

    // directed sequence, reset dimensions are all 1
    drill_row_t drill [24] = '{
        '{ROW_WORD, REG_ROWS_A, CMD_WR_A, 4'd0,  4'd0,  32'h7fffffff, 1'b0, 32'h0, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_WR_B, 4'd0,  4'd0,  32'h00000001, 1'b0, 32'h0, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_SUM,  4'd0,  4'd0,  32'h0, 1'b1, 32'h80000000, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_PROD, 4'd0,  4'd0,  32'h0, 1'b1, 32'h7fffffff, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_SUM,  4'd1,  4'd0,  32'h0, 1'b1, 32'h0, ST_INDEX},
        '{ROW_WORD, REG_ROWS_A, CMD_SUM,  4'd0,  4'd1,  32'h0, 1'b1, 32'h0, ST_INDEX},
        '{ROW_WORD, REG_ROWS_A, CMD_PROD, 4'd15, 4'd15, 32'h0, 1'b1, 32'h0, ST_INDEX},
        // writes land anywhere in the store whatever the dimensions
        '{ROW_WORD, REG_ROWS_A, CMD_WR_A, 4'd15, 4'd15, 32'h80000000, 1'b0, 32'h0, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_WR_B, 4'd15, 4'd15, 32'hffffffff, 1'b0, 32'h0, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_WR_A, 4'd0,  4'd0,  32'h80000000, 1'b0, 32'h0, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_WR_B, 4'd0,  4'd0,  32'h80000000, 1'b0, 32'h0, ST_OK},
        // sum and product both wrap to zero
        '{ROW_WORD, REG_ROWS_A, CMD_SUM,  4'd0,  4'd0,  32'h0, 1'b1, 32'h0, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_PROD, 4'd0,  4'd0,  32'h0, 1'b1, 32'h0, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_WR_A, 4'd0,  4'd0,  32'hffffffff, 1'b0, 32'h0, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_WR_B, 4'd0,  4'd0,  32'hffffffff, 1'b0, 32'h0, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_PROD, 4'd0,  4'd0,  32'h0, 1'b1, 32'h00000001, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_SUM,  4'd0,  4'd0,  32'h0, 1'b1, 32'hfffffffe, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_WR_A, 4'd5,  4'd10, 32'h12345678, 1'b0, 32'h0, ST_OK},
        // rows_a != rows_b breaks the sum, product only fails the row check
        '{ROW_CFG,  REG_ROWS_A, CMD_WR_A, 4'd0,  4'd0,  32'd2, 1'b0, 32'h0, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_SUM,  4'd0,  4'd0,  32'h0, 1'b1, 32'h0, ST_DIM},
        '{ROW_WORD, REG_ROWS_A, CMD_PROD, 4'd2,  4'd0,  32'h0, 1'b1, 32'h0, ST_INDEX},
        // zero-size dimension is unusable for both reads
        '{ROW_CFG,  REG_COLS_A, CMD_WR_A, 4'd0,  4'd0,  32'd0, 1'b0, 32'h0, ST_OK},
        '{ROW_WORD, REG_ROWS_A, CMD_PROD, 4'd0,  4'd0,  32'h0, 1'b1, 32'h0, ST_DIM},
        '{ROW_WORD, REG_ROWS_A, CMD_SUM,  4'd1,  4'd1,  32'h0, 1'b1, 32'h0, ST_DIM}
    };

    // dimension sets for the random phases: square, chained, mismatched, skinny,
    // out-of-range register values, sum-only
    dim_t phase_dims [FIXED_PHASES][4] = '{
        '{5'd16, 5'd16, 5'd16, 5'd16},
        '{5'd3,  5'd4,  5'd4,  5'd2},
        '{5'd5,  5'd5,  5'd5,  5'd5},
        '{5'd2,  5'd7,  5'd3,  5'd6},
        '{5'd16, 5'd1,  5'd1,  5'd16},
        '{5'd1,  5'd16, 5'd16, 5'd1},
        '{5'd0,  5'd31, 5'd0,  5'd31},
        '{5'd4,  5'd3,  5'd4,  5'd3},
        '{5'd17, 5'd16, 5'd16, 5'd16}
    };
    int phase_words [FIXED_PHASES] = '{150, 200, 200, 100, 200, 150, 60, 150, 50};

    matrix_add_multiply_engine_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit size_in_use(input dim_t d);
        return (d >= 1) && (d <= MAX_DIM);
    endfunction

    // dimension check first, then index check
    function automatic status_t read_status(input cmd_t cmd, input idx_t r, input idx_t c);
        if (cmd == CMD_SUM) begin
            if (!size_in_use(dims[REG_ROWS_A]) || !size_in_use(dims[REG_COLS_A]) ||
                dims[REG_ROWS_A] != dims[REG_ROWS_B] || dims[REG_COLS_A] != dims[REG_COLS_B])
                return ST_DIM;
            if (r >= dims[REG_ROWS_A] || c >= dims[REG_COLS_A])
                return ST_INDEX;
        end else if (cmd == CMD_PROD) begin
            if (!size_in_use(dims[REG_ROWS_A]) || !size_in_use(dims[REG_COLS_A]) ||
                !size_in_use(dims[REG_COLS_B]) || dims[REG_COLS_A] != dims[REG_ROWS_B])
                return ST_DIM;
            if (r >= dims[REG_ROWS_A] || c >= dims[REG_COLS_B])
                return ST_INDEX;
        end
        return ST_OK;
    endfunction

    // applies one accepted word to the shadow, returns 1 when it yields a result
    function automatic bit apply_word(input cmd_t cmd, input idx_t r, input idx_t c,
                                      input elem_t v, output elem_t val, output status_t st);
        elem_t acc;
        val = '0;
        st  = read_status(cmd, r, c);
        case (cmd)
            CMD_WR_A: begin
                shadow_a[{r, c}] = v;
                loaded_a[{r, c}] = 1'b1;
                return 1'b0;
            end
            CMD_WR_B: begin
                shadow_b[{r, c}] = v;
                loaded_b[{r, c}] = 1'b1;
                return 1'b0;
            end
            CMD_SUM: begin
                if (st == ST_OK)
                    val = shadow_a[{r, c}] + shadow_b[{r, c}];
            end
            default: begin
                if (st == ST_OK) begin
                    // multiply-accumulate over the inner dimension, wrapping at 32 bits
                    acc = '0;
                    for (int k = 0; k < dims[REG_COLS_A]; k++)
                        acc = acc + shadow_a[{r, idx_t'(k)}] * shadow_b[{idx_t'(k), c}];
                    val = acc;
                end
            end
        endcase
        return 1'b1;
    endfunction

    function automatic elem_t random_value();
        case ($urandom_range(19))
            0:       return 32'h80000000;
            1:       return 32'h7fffffff;
            2:       return 32'hffffffff;
            3:       return 32'h00000000;
            default: return elem_t'($urandom());
        endcase
    endfunction

    // mostly inside the configured size, sometimes anywhere
    function automatic idx_t pick_index(input dim_t d);
        if (size_in_use(d) && $urandom_range(99) < 85)
            return idx_t'($urandom_range(d - 1));
        return idx_t'($urandom_range(MAX_DIM - 1));
    endfunction

    // offers one word, waits for the handshake, then records what it should yield
    task automatic send_word(input cmd_t cmd, input idx_t r, input idx_t c, input elem_t v,
                             input bit typed = 1'b0, input elem_t typed_val = '0,
                             input status_t typed_st = ST_OK);
        elem_t   val;
        status_t st;
        // idling schedule: receiver-heavy, then sender-heavy, then none
        if (sent_words < 650) begin
            send_idle_pct = 38;
            recv_idle_pct = 52;
        end else if (sent_words < 1300) begin
            send_idle_pct = 52;
            recv_idle_pct = 38;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - 42){1'b0}}, v, c, r, cmd};
        do @(posedge aclk); while (!s_tready);
        sent_words++;
        if (apply_word(cmd, r, c, v, val, st)) begin
            // directed rows with a known answer use it instead of the shadow
            if (typed)
                pending_results.push_back('{typed_val, typed_st});
            else
                pending_results.push_back('{val, st});
        end
    endtask

    // sender stops and waits for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // dimension registers change only with the engine idle
    task automatic write_reg(input reg_idx_t idx, input dim_t val);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        dims[idx] = val;
    endtask

    // one random word; a read that would pass first gets its operands loaded
    task automatic random_item();
        int   pick;
        cmd_t cmd;
        idx_t r;
        idx_t c;
        pick = $urandom_range(99);
        cmd  = (pick < 25) ? CMD_WR_A : (pick < 50) ? CMD_WR_B :
               (pick < 75) ? CMD_SUM : CMD_PROD;
        if (cmd == CMD_WR_A || cmd == CMD_WR_B) begin
            send_word(cmd, idx_t'($urandom_range(MAX_DIM - 1)),
                      idx_t'($urandom_range(MAX_DIM - 1)), random_value());
            return;
        end
        r = pick_index(dims[REG_ROWS_A]);
        c = pick_index((cmd == CMD_SUM) ? dims[REG_COLS_A] : dims[REG_COLS_B]);
        if (read_status(cmd, r, c) == ST_OK) begin
            if (cmd == CMD_SUM) begin
                if (!loaded_a[{r, c}])
                    send_word(CMD_WR_A, r, c, random_value());
                if (!loaded_b[{r, c}])
                    send_word(CMD_WR_B, r, c, random_value());
            end else begin
                for (int k = 0; k < dims[REG_COLS_A]; k++) begin
                    if (!loaded_a[{r, idx_t'(k)}])
                        send_word(CMD_WR_A, r, idx_t'(k), random_value());
                    if (!loaded_b[{idx_t'(k), c}])
                        send_word(CMD_WR_B, idx_t'(k), c, random_value());
                end
            end
        end
        // write_value is ignored on reads, so it carries noise
        send_word(cmd, r, c, elem_t'($urandom()));
    endtask

    // receiver: random backpressure, plus one long stall on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker, oldest expectation first
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected, expected none, actual %h",
                         $time, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[ELEM_W-1:0] !== want.value) begin
                    $display("%0t: result_value mismatch, expected %h, actual %h",
                             $time, want.value, m_tdata[ELEM_W-1:0]);
                    errors++;
                end
                if (m_tdata[ELEM_W +: STATUS_W] !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_tdata[ELEM_W +: STATUS_W]);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("matrix_add_multiply_engine_core_tb: FAIL");
            $finish;
        end
    end

    initial begin
        dim_t next_dims [4];
        int   phase_end;
        int   half_way;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed sequence
        foreach (drill[i]) begin
            if (drill[i].kind == ROW_CFG)
                write_reg(drill[i].reg_idx, dim_t'(drill[i].value));
            else
                send_word(drill[i].cmd, drill[i].row, drill[i].col, drill[i].value,
                          drill[i].typed, drill[i].exp_value, drill[i].exp_status);
        end

        // random phases, each under its own dimension set
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < FIXED_PHASES) begin
                next_dims = phase_dims[p];
                phase_end = sent_words + phase_words[p];
            end else begin
                next_dims[REG_ROWS_A] = dim_t'($urandom_range(1, 8));
                next_dims[REG_COLS_A] = dim_t'($urandom_range(1, 8));
                next_dims[REG_ROWS_B] = dim_t'($urandom_range(1, 8));
                next_dims[REG_COLS_B] = dim_t'($urandom_range(1, 8));
                // chain A into B for products half of the time
                if ($urandom_range(1) == 1)
                    next_dims[REG_ROWS_B] = next_dims[REG_COLS_A];
                // sometimes make the sum line up as well
                if ($urandom_range(3) == 0) begin
                    next_dims[REG_ROWS_B] = next_dims[REG_ROWS_A];
                    next_dims[REG_COLS_B] = next_dims[REG_COLS_A];
                end
                phase_end = sent_words + 170;
            end
            for (int j = 0; j < 4; j++)
                write_reg(reg_idx_t'(j), next_dims[j]);
            // long receiver stall while words keep coming, so the input backs up
            if (p == 1)
                hold_req = 1'b1;
            half_way = (sent_words + phase_end) / 2;
            while (sent_words < phase_end) begin
                random_item();
                // pause the sender once per phase until all results are back
                if (sent_words >= half_way && half_way != 0) begin
                    half_way = 0;
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("matrix_add_multiply_engine_core_tb: PASS");
        else
            $display("matrix_add_multiply_engine_core_tb: FAIL");
        $finish;
    end

endmodule
